### rtl/jsu_pkg.sv
package jsu_pkg;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 4;

  // Byte codes that drive the escape decoder
  localparam logic [7:0] BACKSLASH = 8'h5c;
  localparam logic [7:0] LETTER_U  = 8'h75;

  // Top six bits of a UTF-16 code unit that mark a surrogate half
  localparam int         SURR_BITS = 6;
  localparam logic [SURR_BITS-1:0] SURR_HIGH = 6'b110110;
  localparam logic [SURR_BITS-1:0] SURR_LOW  = 6'b110111;

  // Offset added to a combined surrogate pair
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Escape phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ESC     = 4'd1,
    PH_HI0     = 4'd2,
    PH_HI1     = 4'd3,
    PH_HI2     = 4'd4,
    PH_HI3     = 4'd5,
    PH_WAIT_BS = 4'd6,
    PH_WAIT_U  = 4'd7,
    PH_LO0     = 4'd8,
    PH_LO1     = 4'd9,
    PH_LO2     = 4'd10,
    PH_LO3     = 4'd11
  } jsu_phase_t;

  // One group of results caused by one input word
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            has_data;
    logic            done;
    logic            err;
  } jsu_group_t;

  // Hex digit decode: {ok, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Single-letter escape decode: {ok, byte}
  function automatic logic [8:0] escape_byte(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h22:   r = {1'b1, 8'h22};
      8'h5c:   r = {1'b1, 8'h5c};
      8'h2f:   r = {1'b1, 8'h2f};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/jsu_front.sv
module jsu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                validate_only,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                end_of_input,
  output logic                push,
  output jsu_pkg::jsu_group_t group
);

  jsu_pkg::jsu_phase_t phase, phase_next;
  logic [15:0] code_unit, code_unit_next;
  logic [9:0]  high_half, high_half_next;
  logic        error_seen, error_seen_next;

  logic [4:0]  hexd;
  logic [8:0]  escd;
  logic [15:0] cu_shift;
  logic [20:0] cp;
  logic [3:0][7:0] data;
  logic [2:0]  nd;
  logic [2:0]  nd_eff;

  // Hold escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= jsu_pkg::PH_IDLE;
      code_unit  <= 16'd0;
      high_half  <= 10'd0;
      error_seen <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      code_unit  <= code_unit_next;
      high_half  <= high_half_next;
      error_seen <= error_seen_next;
    end
  end

  assign hexd     = jsu_pkg::hex_value(in_byte);
  assign escd     = jsu_pkg::escape_byte(in_byte);
  assign cu_shift = {code_unit[11:0], hexd[3:0]};
  assign cp       = jsu_pkg::SUPP_BASE + {1'b0, high_half, cu_shift[9:0]};

  // Classify the word and advance the escape phase
  always_comb begin
    phase_next      = phase;
    code_unit_next  = code_unit;
    high_half_next  = high_half;
    error_seen_next = error_seen;
    data            = '0;
    nd              = 3'd0;
    if (!error_seen) begin
      unique case (phase)
        jsu_pkg::PH_IDLE: begin
          if (in_byte == jsu_pkg::BACKSLASH) begin
            phase_next = jsu_pkg::PH_ESC;
          end else begin
            data[0] = in_byte;
            nd      = 3'd1;
          end
        end
        jsu_pkg::PH_ESC: begin
          if (in_byte == jsu_pkg::LETTER_U) begin
            code_unit_next = 16'd0;
            phase_next     = jsu_pkg::PH_HI0;
          end else if (escd[8]) begin
            data[0]    = escd[7:0];
            nd         = 3'd1;
            phase_next = jsu_pkg::PH_IDLE;
          end else begin
            error_seen_next = 1'b1;
            phase_next      = jsu_pkg::PH_IDLE;
          end
        end
        jsu_pkg::PH_HI0, jsu_pkg::PH_HI1, jsu_pkg::PH_HI2,
        jsu_pkg::PH_LO0, jsu_pkg::PH_LO1, jsu_pkg::PH_LO2: begin
          if (hexd[4]) begin
            code_unit_next = cu_shift;
            phase_next     = jsu_pkg::jsu_phase_t'(phase + 4'd1);
          end else begin
            error_seen_next = 1'b1;
            phase_next      = jsu_pkg::PH_IDLE;
          end
        end
        jsu_pkg::PH_HI3: begin
          code_unit_next = cu_shift;
          phase_next     = jsu_pkg::PH_IDLE;
          if (!hexd[4] || cu_shift[15 -: jsu_pkg::SURR_BITS] == jsu_pkg::SURR_LOW) begin
            error_seen_next = 1'b1;
          end else if (cu_shift[15 -: jsu_pkg::SURR_BITS] == jsu_pkg::SURR_HIGH) begin
            high_half_next = cu_shift[9:0];
            phase_next     = jsu_pkg::PH_WAIT_BS;
          end else if (cu_shift < 16'h0080) begin
            data[0] = cu_shift[7:0];
            nd      = 3'd1;
          end else if (cu_shift < 16'h0800) begin
            data[0] = {3'b110, cu_shift[10:6]};
            data[1] = {2'b10, cu_shift[5:0]};
            nd      = 3'd2;
          end else begin
            data[0] = {4'b1110, cu_shift[15:12]};
            data[1] = {2'b10, cu_shift[11:6]};
            data[2] = {2'b10, cu_shift[5:0]};
            nd      = 3'd3;
          end
        end
        jsu_pkg::PH_LO3: begin
          code_unit_next = cu_shift;
          phase_next     = jsu_pkg::PH_IDLE;
          if (hexd[4] && cu_shift[15 -: jsu_pkg::SURR_BITS] == jsu_pkg::SURR_LOW) begin
            data[0] = {5'b11110, cp[20:18]};
            data[1] = {2'b10, cp[17:12]};
            data[2] = {2'b10, cp[11:6]};
            data[3] = {2'b10, cp[5:0]};
            nd      = 3'd4;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        jsu_pkg::PH_WAIT_BS: begin
          if (in_byte == jsu_pkg::BACKSLASH) begin
            phase_next = jsu_pkg::PH_WAIT_U;
          end else begin
            error_seen_next = 1'b1;
            phase_next      = jsu_pkg::PH_IDLE;
          end
        end
        jsu_pkg::PH_WAIT_U: begin
          if (in_byte == jsu_pkg::LETTER_U) begin
            code_unit_next = 16'd0;
            phase_next     = jsu_pkg::PH_LO0;
          end else begin
            error_seen_next = 1'b1;
            phase_next      = jsu_pkg::PH_IDLE;
          end
        end
        default: begin
          error_seen_next = 1'b1;
          phase_next      = jsu_pkg::PH_IDLE;
        end
      endcase
    end

    // Build the group for the queue
    nd_eff         = validate_only ? 3'd0 : nd;
    group.bytes    = data;
    group.has_data = (nd_eff != 3'd0);
    group.last_idx = (nd_eff == 3'd0) ? 2'd0 : 2'(nd_eff - 3'd1);
    group.done     = end_of_input;
    group.err      = end_of_input &&
                     (error_seen_next || (phase_next != jsu_pkg::PH_IDLE));
    push           = accept && (end_of_input || nd_eff != 3'd0);

    // Close the string: drop all escape state
    if (end_of_input) begin
      phase_next      = jsu_pkg::PH_IDLE;
      code_unit_next  = 16'd0;
      high_half_next  = 10'd0;
      error_seen_next = 1'b0;
    end
  end

endmodule

### rtl/jsu_queue.sv
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  jsu_pkg::jsu_group_t wr_group,
  input  logic                pop,
  output jsu_pkg::jsu_group_t head,
  output logic                head_valid,
  output logic                full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::jsu_group_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CW'(DEPTH));

  // Store incoming groups
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_group;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/jsu_back.sv
module jsu_back (
  input  logic                clk,
  input  logic                rst,
  input  jsu_pkg::jsu_group_t head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                has_data,
  output logic                string_done,
  output logic                parse_error,
  output logic                run_last
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  assign load    = head_valid && (!out_valid || out_ready);
  assign is_last = (idx == head.last_idx);
  assign pop     = load && is_last;

  // Step through the bytes of the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head.has_data ? head.bytes[idx] : 8'd0;
      has_data    <= head.has_data;
      string_done <= head.done && is_last;
      parse_error <= head.err && is_last;
      run_last    <= is_last;
    end
  end

endmodule

### rtl/json_string_unescape.sv
// JSON string body unescaper: one input word per cycle when the queue has room.
// With the queue empty, a result word passes through its group queue slot and then the
// output register of the back end before it is presented.
// Throughput: one output word per cycle while out_ready is high; a \u escape giving n
// bytes yields n words from the group queue, paced by the single back end output register.
// Reset (rst, synchronous): clears escape state, queue and output; validate_only to 0.
module json_string_unescape #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_data,
  output logic       string_done,
  output logic       parse_error,
  output logic       run_last
);

  logic                validate_only;
  logic                accept;
  logic                push;
  logic                pop;
  logic                full;
  logic                head_valid;
  jsu_pkg::jsu_group_t group;
  jsu_pkg::jsu_group_t head;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      validate_only <= 1'b0;
    end else if (cfg_write) begin
      validate_only <= cfg_data;
    end
  end

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  jsu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .validate_only (validate_only),
    .accept        (accept),
    .in_byte       (in_byte),
    .end_of_input  (end_of_input),
    .push          (push),
    .group         (group)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_group   (group),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_data     (has_data),
    .string_done  (string_done),
    .parse_error  (parse_error),
    .run_last     (run_last)
  );

endmodule

### tb/sv/json_string_unescape_tb.sv
module json_string_unescape_tb;

  localparam int STUCK_LIMIT = 400;
  localparam int PHASE_WORDS = 50;

  // One expected output word
  typedef struct packed {
    logic [7:0] value;
    logic       data;
    logic       done;
    logic       err;
    logic       last;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic       cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       has_data;
  logic       string_done;
  logic       parse_error;
  logic       run_last;

  // Predictor state
  jsu_pkg::jsu_phase_t esc_phase;
  logic [15:0] unit_acc;
  logic [9:0]  surr_hi;
  logic        err_latched;
  logic        validate_mode;

  decoded_t   decoded_q[$];
  logic [7:0] text_q[$];
  int         mismatch_count;
  int         words_sent;
  int         stuck_cycles;
  int         stall_left;
  bit         calm;

  json_string_unescape dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .has_data     (has_data),
    .string_done  (string_done),
    .parse_error  (parse_error),
    .run_last     (run_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Value of a hex digit, or -1 if the byte is not one
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    case (c)
      8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int to_utf8(input logic [20:0] cp, output logic [3:0][7:0] o);
    o = '0;
    if (cp < 21'h80) begin
      o[0] = cp[7:0];
      return 1;
    end
    if (cp < 21'h800) begin
      o[0] = {3'b110, cp[10:6]};
      o[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 21'h10000) begin
      o[0] = {4'b1110, cp[15:12]};
      o[1] = {2'b10, cp[11:6]};
      o[2] = {2'b10, cp[5:0]};
      return 3;
    end
    o[0] = {5'b11110, cp[20:18]};
    o[1] = {2'b10, cp[17:12]};
    o[2] = {2'b10, cp[11:6]};
    o[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  function automatic void flag_error();
    err_latched = 1'b1;
    esc_phase   = jsu_pkg::PH_IDLE;
  endfunction

  // Advance the decoder by one input word and queue the words it gives
  function automatic void decode_word(input logic [7:0] c, input logic eoi);
    logic [3:0][7:0] outb;
    int              n;
    int              nres;
    int              d;
    decoded_t        r;
    n = 0;
    outb = '0;
    if (!err_latched) begin
      case (esc_phase)
        jsu_pkg::PH_IDLE: begin
          if (c == jsu_pkg::BACKSLASH) esc_phase = jsu_pkg::PH_ESC;
          else begin
            outb[0] = c;
            n = 1;
          end
        end
        jsu_pkg::PH_ESC: begin
          if (c == jsu_pkg::LETTER_U) begin
            unit_acc  = '0;
            esc_phase = jsu_pkg::PH_HI0;
          end else begin
            n = 1;
            case (c)
              8'h22, 8'h5c, 8'h2f: outb[0] = c;
              8'h62: outb[0] = 8'h08;
              8'h66: outb[0] = 8'h0c;
              8'h6e: outb[0] = 8'h0a;
              8'h72: outb[0] = 8'h0d;
              8'h74: outb[0] = 8'h09;
              default: n = 0;
            endcase
            if (n == 1) esc_phase = jsu_pkg::PH_IDLE;
            else flag_error();
          end
        end
        jsu_pkg::PH_HI0, jsu_pkg::PH_HI1, jsu_pkg::PH_HI2, jsu_pkg::PH_HI3,
        jsu_pkg::PH_LO0, jsu_pkg::PH_LO1, jsu_pkg::PH_LO2, jsu_pkg::PH_LO3: begin
          d = hex_digit(c);
          if (d < 0) flag_error();
          else begin
            unit_acc = {unit_acc[11:0], 4'(d)};
            if (esc_phase == jsu_pkg::PH_HI3) begin
              if (unit_acc[15:10] == jsu_pkg::SURR_HIGH) begin
                surr_hi   = unit_acc[9:0];
                esc_phase = jsu_pkg::PH_WAIT_BS;
              end else if (unit_acc[15:10] == jsu_pkg::SURR_LOW) begin
                flag_error();
              end else begin
                n = to_utf8({5'd0, unit_acc}, outb);
                esc_phase = jsu_pkg::PH_IDLE;
              end
            end else if (esc_phase == jsu_pkg::PH_LO3) begin
              if (unit_acc[15:10] == jsu_pkg::SURR_LOW) begin
                n = to_utf8(jsu_pkg::SUPP_BASE + {1'b0, surr_hi, unit_acc[9:0]}, outb);
                esc_phase = jsu_pkg::PH_IDLE;
              end else begin
                flag_error();
              end
            end else begin
              esc_phase = jsu_pkg::jsu_phase_t'(esc_phase + 1);
            end
          end
        end
        jsu_pkg::PH_WAIT_BS: begin
          if (c == jsu_pkg::BACKSLASH) esc_phase = jsu_pkg::PH_WAIT_U;
          else flag_error();
        end
        jsu_pkg::PH_WAIT_U: begin
          if (c == jsu_pkg::LETTER_U) begin
            unit_acc  = '0;
            esc_phase = jsu_pkg::PH_LO0;
          end else flag_error();
        end
        default: flag_error();
      endcase
    end

    if (validate_mode) n = 0;
    nres = n;
    if (eoi && nres == 0) nres = 1;
    for (int k = 0; k < nres; k++) begin
      r.value = (k < n) ? outb[k] : 8'h00;
      r.data  = (k < n);
      r.last  = (k == nres - 1);
      r.done  = eoi && r.last;
      r.err   = r.done ? (err_latched || esc_phase != jsu_pkg::PH_IDLE) : 1'b0;
      decoded_q.push_back(r);
    end

    // Close the string: drop all escape state
    if (eoi) begin
      esc_phase   = jsu_pkg::PH_IDLE;
      unit_acc    = '0;
      surr_hi     = '0;
      err_latched = 1'b0;
    end
  endfunction

  // Present one word, hold it until taken, then predict
  task automatic send_word(input logic [7:0] c, input logic eoi);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_byte      = c;
    end_of_input = eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_word(c, eoi);
    words_sent++;
  endtask

  task automatic send_text(input bit close);
    logic [7:0] c;
    while (text_q.size() > 0) begin
      c = text_q.pop_front();
      send_word(c, close && text_q.size() == 0);
    end
  endtask

  // Drop valid and let the block drain completely
  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_mode(input logic v);
    wait_quiet();
    cfg_write = 1'b1;
    cfg_data  = v;
    @(negedge clk);
    cfg_write     = 1'b0;
    validate_mode = v;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'd0, nib};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, nib} - 8'd10;
  endfunction

  function automatic void push_unit(input logic [15:0] u);
    text_q.push_back(jsu_pkg::BACKSLASH);
    text_q.push_back(jsu_pkg::LETTER_U);
    for (int i = 3; i >= 0; i--) text_q.push_back(hex_char(u[i*4 +: 4]));
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    c = 8'($urandom);
    while (hex_digit(c) >= 0) c = 8'($urandom);
    return c;
  endfunction

  // Build one string: mostly well-formed segments, a few broken ones
  function automatic void build_random_string();
    int         nseg;
    int         kind;
    int         cut;
    logic [7:0] c;
    logic [15:0] u;
    text_q.delete();
    nseg = $urandom_range(1, 6);
    for (int s = 0; s < nseg; s++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        c = 8'($urandom);
        if (c == jsu_pkg::BACKSLASH) c = 8'h41;
        text_q.push_back(c);
      end else if (kind < 50) begin
        text_q.push_back(jsu_pkg::BACKSLASH);
        case ($urandom_range(0, 7))
          0: text_q.push_back(8'h22);
          1: text_q.push_back(8'h5c);
          2: text_q.push_back(8'h2f);
          3: text_q.push_back(8'h62);
          4: text_q.push_back(8'h66);
          5: text_q.push_back(8'h6e);
          6: text_q.push_back(8'h72);
          default: text_q.push_back(8'h74);
        endcase
      end else if (kind < 70) begin
        case ($urandom_range(0, 2))
          0: u = 16'($urandom_range(0, 'h7f));
          1: u = 16'($urandom_range('h80, 'h7ff));
          default: u = 16'($urandom_range('h800, 'hffff));
        endcase
        if (u[15:11] == 5'b11011) u = u ^ 16'h2000;
        push_unit(u);
      end else if (kind < 82) begin
        push_unit({jsu_pkg::SURR_HIGH, 10'($urandom)});
        push_unit({jsu_pkg::SURR_LOW, 10'($urandom)});
      end else if (kind < 86) begin
        c = 8'($urandom);
        while (is_escape_letter(c) || c == jsu_pkg::LETTER_U) c = 8'($urandom);
        text_q.push_back(jsu_pkg::BACKSLASH);
        text_q.push_back(c);
      end else if (kind < 89) begin
        text_q.push_back(jsu_pkg::BACKSLASH);
        text_q.push_back(jsu_pkg::LETTER_U);
        cut = $urandom_range(0, 3);
        for (int i = 0; i < cut; i++) text_q.push_back(hex_char(4'($urandom)));
        text_q.push_back(non_hex_byte());
      end else if (kind < 92) begin
        push_unit({jsu_pkg::SURR_LOW, 10'($urandom)});
      end else if (kind < 96) begin
        push_unit({jsu_pkg::SURR_HIGH, 10'($urandom)});
        case ($urandom_range(0, 2))
          0: begin
            c = 8'($urandom);
            if (c == jsu_pkg::BACKSLASH) c = 8'h7a;
            text_q.push_back(c);
          end
          1: begin
            c = 8'($urandom);
            if (c == jsu_pkg::LETTER_U) c = 8'h6e;
            text_q.push_back(jsu_pkg::BACKSLASH);
            text_q.push_back(c);
          end
          default: begin
            u = 16'($urandom);
            if (u[15:10] == jsu_pkg::SURR_LOW) u[10] = 1'b0;
            push_unit(u);
          end
        endcase
      end else begin
        cut = $urandom_range(1, 4);
        for (int i = 0; i < cut; i++) text_q.push_back(8'($urandom));
      end
    end
    // Cut the tail now and then so the string can end inside an escape
    if (text_q.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, (text_q.size() > 3) ? 3 : text_q.size() - 1);
      for (int i = 0; i < cut; i++) void'(text_q.pop_back());
    end
  endfunction

  // Plain extremes, a short escape and a surrogate pair in one string
  task automatic test_passthrough_and_pair();
    text_q = '{8'h00, 8'hff, jsu_pkg::BACKSLASH, 8'h6e};
    push_unit(16'hd83d);
    push_unit(16'hde00);
    send_text(1'b1);
  endtask

  task automatic test_malformed_escapes();
    // bad escape letter, then bytes swallowed until the end
    text_q = '{jsu_pkg::BACKSLASH, 8'h71, 8'h41};
    send_text(1'b1);
    // lone trailing backslash
    text_q = '{jsu_pkg::BACKSLASH};
    send_text(1'b1);
    // non-hex byte where a digit is due
    text_q = '{jsu_pkg::BACKSLASH, jsu_pkg::LETTER_U, 8'h67};
    send_text(1'b1);
    // low surrogate with no high half
    push_unit(16'hdc00);
    send_text(1'b1);
    // high surrogate followed by a plain byte
    push_unit(16'hd800);
    text_q.push_back(8'h78);
    send_text(1'b1);
  endtask

  // Flip to validate-only part way through a string, then back
  task automatic test_mode_switch();
    text_q = '{8'h61, jsu_pkg::BACKSLASH, jsu_pkg::LETTER_U, 8'h30};
    send_text(1'b0);
    set_mode(1'b1);
    text_q = '{8'h30, 8'h65, 8'h39};
    send_text(1'b1);
    set_mode(1'b0);
  endtask

  task automatic run_random();
    int start;
    for (int p = 0; p < 5; p++) begin
      set_mode(1'(p % 2));
      if (p == 4) calm = 1'b1;
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) begin
        build_random_string();
        send_text(1'b1);
      end
    end
  endtask

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each output word with the oldest prediction
  always @(posedge clk) begin : result_check
    decoded_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h/%b%b%b%b", $time,
                 out_byte, has_data, string_done, parse_error, run_last);
        mismatch_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.value, out_byte);
        check_field("has_data", {7'd0, want.data}, {7'd0, has_data});
        check_field("string_done", {7'd0, want.done}, {7'd0, string_done});
        check_field("parse_error", {7'd0, want.err}, {7'd0, parse_error});
        check_field("run_last", {7'd0, want.last}, {7'd0, run_last});
      end
    end
  end

  // Stall the output side in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(1, 10) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("json_string_unescape_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_data       = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    end_of_input   = 1'b0;
    out_ready      = 1'b1;
    stall_left     = 0;
    calm           = 1'b0;
    mismatch_count = 0;
    words_sent     = 0;
    stuck_cycles   = 0;
    esc_phase      = jsu_pkg::PH_IDLE;
    unit_acc       = '0;
    surr_hi        = '0;
    err_latched    = 1'b0;
    validate_mode  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_mode(1'b0);
    test_passthrough_and_pair();
    test_malformed_escapes();
    test_mode_switch();
    run_random();

    // Drain and settle
    @(negedge clk);
    in_valid = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("json_string_unescape_tb: done, clean");
    end else begin
      $display("json_string_unescape_tb: done, errors");
    end
    $finish;
  end

endmodule
